// ----- design/scfd_pkg.sv -----
// shared types and constants for the serial command frame decoder
`default_nettype none

package scfd_pkg;

  // frame delimiters and letters
  localparam logic [7:0] CH_OPEN  = 8'h24;  // '$'
  localparam logic [7:0] CH_CLOSE = 8'h23;  // '#'
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_STEER = 8'h53;  // 'S'
  localparam logic [7:0] CH_MOTOR = 8'h4D;  // 'M'
  localparam logic [7:0] CH_SPEED = 8'h43;  // 'C'
  localparam logic [7:0] CH_STOP  = 8'h54;  // 'T'
  localparam logic [7:0] CH_PROP  = 8'h50;  // 'P'
  localparam logic [7:0] CH_INTEG = 8'h49;  // 'I'
  localparam logic [7:0] CH_DERIV = 8'h44;  // 'D'

  localparam int unsigned POS_W = 7;
  localparam logic [POS_W-1:0] POS_MAX = 7'd127;

  localparam logic [15:0] SPEED_MAX_RST   = 16'hFFFF;
  localparam logic [6:0]  FRAME_LIMIT_RST = 7'd98;

  // register byte addresses
  localparam int unsigned ADDR_W = 3;
  localparam logic [ADDR_W-1:0] ADDR_SPEED_MAX   = 3'd0;
  localparam logic [ADDR_W-1:0] ADDR_FRAME_LIMIT = 3'd4;

  typedef enum logic [2:0] {
    KIND_STEER = 3'd0,
    KIND_MOTOR = 3'd1,
    KIND_SPEED = 3'd2,
    KIND_STOP  = 3'd3,
    KIND_ERROR = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    GAIN_PROP  = 2'd0,
    GAIN_INTEG = 2'd1,
    GAIN_DERIV = 2'd2
  } gain_sel_t;

  typedef struct packed {
    kind_t       kind;
    gain_sel_t   gain_select;
    logic [15:0] value;
  } cmd_t;

  typedef struct packed {
    logic [15:0] speed_max;
    logic [6:0]  frame_limit;
  } cfg_t;

  // acc * 10 + b - 48, modulo 2^16
  function automatic logic [15:0] fold_digit(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] sum;
    sum = {acc[12:0], 3'b000} + {acc[14:0], 1'b0} + {8'd0, b} - {8'd0, CH_ZERO};
    return sum;
  endfunction

endpackage

`default_nettype wire

// ----- design/serial_command_frame_decoder_top.sv -----
// serial command frame decoder top level: input register, decode, result register
//
// received bytes enter on the rx channel (rx_valid, rx_stall, rx_byte), one
// request per byte. frames open with '$' and close with '#'; each closing '#'
// of a live frame within frame_limit yields one request on the cmd channel
// (cmd_valid, cmd_stall, kind, gain_select, value). all other bytes yield nothing.
// a byte accepted into the input register is decoded from there, and its command
// is captured in the result register that drives cmd_valid.
// throughput: one byte per cycle while no stalled command is pending; the frame
// state update and the decode of a command (one multiply-by-ten fold, letter
// compares, speed clamp) sit between the input register and the result register.
// when cmd_stall holds a pending command, the byte in the input register
// waits and rx_stall rises once that register is full; a pending command
// never changes while stalled.
// speed_max and frame_limit sit behind the apb-style port (byte addresses 0 and 4);
// the user must write them only while the decoder is idle (the block does not enforce it).
// synchronous reset closes any frame, clears both channels and restores
// speed_max 65535 and frame_limit 98.
`default_nettype none

module serial_command_frame_decoder_top
  import scfd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  // byte channel
  input  wire logic              rx_valid,
  output logic                   rx_stall,
  input  wire logic [7:0]        rx_byte,
  // command channel
  output logic                   cmd_valid,
  input  wire logic              cmd_stall,
  output logic [2:0]             kind,
  output logic [1:0]             gain_select,
  output logic [15:0]            value,
  // configuration port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  cfg_t        cfg;
  logic        byte_valid;   // input register holds a byte
  logic [7:0]  byte_reg;
  logic        go;           // input register byte is decoded this cycle
  logic        rx_take;
  logic        res_valid;
  cmd_t        res;
  cmd_t        cmd_reg;

  scfd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // decode proceeds when a byte is held and the result register is free or being drained
  assign go       = byte_valid && (!cmd_valid || !cmd_stall);
  assign rx_stall = byte_valid && !go;
  assign rx_take  = rx_valid && !rx_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (rx_take) begin
      byte_valid <= 1'b1;
    end else if (go) begin
      byte_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_take) begin
      byte_reg <= rx_byte;
    end
  end

  scfd_frame u_frame (
    .clk       (clk),
    .rst       (rst),
    .go        (go),
    .rx_byte   (byte_reg),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (go && res_valid) begin
      cmd_valid <= 1'b1;
    end else if (!cmd_stall) begin
      cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && res_valid) begin
      cmd_reg <= res;
    end
  end

  assign kind        = cmd_reg.kind;
  assign gain_select = cmd_reg.gain_select;
  assign value       = cmd_reg.value;

endmodule

`default_nettype wire

// ----- design/scfd_cfg.sv -----
// configuration register file behind the apb-style port
`default_nettype none

module scfd_cfg
  import scfd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // decode on the word address bit only
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.speed_max   <= SPEED_MAX_RST;
      cfg.frame_limit <= FRAME_LIMIT_RST;
    end else if (wr_en) begin
      if (paddr[2] == ADDR_FRAME_LIMIT[2]) begin
        cfg.frame_limit <= pwdata[6:0];
      end else begin
        cfg.speed_max <= pwdata[15:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == ADDR_FRAME_LIMIT[2]) begin
      prdata = {25'd0, cfg.frame_limit};
    end else begin
      prdata = {16'd0, cfg.speed_max};
    end
  end

endmodule

`default_nettype wire

// ----- design/scfd_frame.sv -----
// frame tracking state and per-byte command decode
`default_nettype none

module scfd_frame
  import scfd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       go,
  input  wire logic [7:0] rx_byte,
  input  wire cfg_t       cfg,
  output logic            res_valid,
  output cmd_t            res
);

  logic             in_frame, in_frame_next;
  logic [POS_W-1:0] position, position_next;
  logic [7:0]       type_letter, type_letter_next;
  logic [7:0]       gain_letter, gain_letter_next;
  logic [15:0]      accum, accum_next;
  logic [15:0]      speed_accum, speed_accum_next;

  logic             open_seen;
  logic             live;
  logic [POS_W-1:0] pos_eff;
  logic [7:0]       type_eff, gain_eff;
  logic [15:0]      accum_eff, speed_eff;

  assign open_seen = (rx_byte == CH_OPEN);
  assign live      = open_seen || in_frame;
  assign pos_eff   = open_seen ? '0 : position;
  assign type_eff  = open_seen ? '0 : type_letter;
  assign gain_eff  = open_seen ? '0 : gain_letter;
  assign accum_eff = open_seen ? '0 : accum;
  assign speed_eff = open_seen ? '0 : speed_accum;

  always_comb begin
    in_frame_next    = in_frame;
    position_next    = position;
    type_letter_next = type_letter;
    gain_letter_next = gain_letter;
    accum_next       = accum;
    speed_accum_next = speed_accum;
    res_valid        = 1'b0;
    res.kind         = KIND_ERROR;
    res.gain_select  = GAIN_PROP;
    res.value        = '0;

    if (live) begin
      in_frame_next    = 1'b1;
      position_next    = pos_eff;
      type_letter_next = type_eff;
      gain_letter_next = gain_eff;
      accum_next       = accum_eff;
      speed_accum_next = speed_eff;

      if (pos_eff > cfg.frame_limit) begin
        // overlong frame: drop silently
        in_frame_next = 1'b0;
      end else if (rx_byte == CH_CLOSE) begin
        res_valid     = 1'b1;
        in_frame_next = 1'b0;
        position_next = '0;
        if ((type_eff == CH_STEER) || (type_eff == CH_MOTOR)) begin
          if ((gain_eff == CH_PROP) || (gain_eff == CH_INTEG) || (gain_eff == CH_DERIV)) begin
            res.kind  = (type_eff == CH_STEER) ? KIND_STEER : KIND_MOTOR;
            res.value = accum_eff;
            if (gain_eff == CH_INTEG) begin
              res.gain_select = GAIN_INTEG;
            end else if (gain_eff == CH_DERIV) begin
              res.gain_select = GAIN_DERIV;
            end
          end
        end else if (type_eff == CH_SPEED) begin
          res.kind  = KIND_SPEED;
          res.value = (speed_eff > cfg.speed_max) ? cfg.speed_max : speed_eff;
        end else if (type_eff == CH_STOP) begin
          res.kind = KIND_STOP;
        end
      end else begin
        if (pos_eff == 7'd1) begin
          type_letter_next = rx_byte;
        end else if (pos_eff == 7'd2) begin
          gain_letter_next = rx_byte;
          speed_accum_next = fold_digit(speed_eff, rx_byte);
        end else if (pos_eff >= 7'd3) begin
          accum_next       = fold_digit(accum_eff, rx_byte);
          speed_accum_next = fold_digit(speed_eff, rx_byte);
        end
        if (pos_eff != POS_MAX) begin
          position_next = pos_eff + 7'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame    <= 1'b0;
      position    <= '0;
      type_letter <= '0;
      gain_letter <= '0;
      accum       <= '0;
      speed_accum <= '0;
    end else if (go) begin
      in_frame    <= in_frame_next;
      position    <= position_next;
      type_letter <= type_letter_next;
      gain_letter <= gain_letter_next;
      accum       <= accum_next;
      speed_accum <= speed_accum_next;
    end
  end

  a_close_ends_frame: assert property (@(posedge clk) disable iff (rst)
    go && res_valid |=> !in_frame && (position == '0))
    else $error("frame still open after a command result");

  a_error_is_blank: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.kind == KIND_ERROR) |-> (res.value == '0) && (res.gain_select == GAIN_PROP))
    else $error("error result carries a value or gain select");

  a_speed_clamped: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.kind == KIND_SPEED) |-> (res.value <= cfg.speed_max))
    else $error("speed target above configured maximum");

  a_open_starts_frame: assert property (@(posedge clk) disable iff (rst)
    go && (rx_byte == CH_OPEN) && (cfg.frame_limit != '0) |=> in_frame && (position == 7'd1))
    else $error("open byte did not start a frame");

endmodule

`default_nettype wire
